>>> src/assert_macros.svh
// Assertion macros shared by the sprite pixel blitter RTL.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);

`endif

>>> src/spb_pkg.sv
`timescale 1ns / 1ps
// Types and constants of the sprite pixel blitter.
// No dependencies; the interface, RAM and top level files follow it.
package spb_pkg;

  // Configuration register indexes
  typedef logic [3:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ORIGIN_X    = 4'd0;
  localparam cfg_idx_t CFG_ORIGIN_Y    = 4'd1;
  localparam cfg_idx_t CFG_SCALE       = 4'd2;
  localparam cfg_idx_t CFG_FLIP        = 4'd3;
  localparam cfg_idx_t CFG_FRAME_INDEX = 4'd4;
  localparam cfg_idx_t CFG_FRAME_W     = 4'd5;
  localparam cfg_idx_t CFG_FRAME_H     = 4'd6;
  localparam cfg_idx_t CFG_FRAMES      = 4'd7;

  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [31:0] ALPHA_MASK = 32'hff00_0000;
  localparam logic [31:0] COLOR_MASK = 32'h00ff_ffff;

  // Fixed point shift of the scale reciprocal
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_W     = 17;

  // Result queue entries
  localparam int unsigned FIFO_DEPTH = 8;

  typedef struct packed {
    cfg_idx_t                index;
    logic [CFG_DATA_W-1:0]   wdata;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [11:0] load_addr;
    logic [31:0] load_pixel;
    logic [9:0]  target_x;
    logic [9:0]  target_y;
  } in_t;

  typedef struct packed {
    logic        write_enable;
    logic [31:0] pixel_color;
    logic [19:0] target_addr;
  } out_t;

  // ceil(2^16 / s), scale zero acts as one; exact floor division for offsets below 2048
  function automatic logic [RECIP_W-1:0] scale_recip(input logic [3:0] s);
    logic [RECIP_W-1:0] r;
    case (s)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      4'd10:   r = 17'd6554;
      4'd11:   r = 17'd5958;
      4'd12:   r = 17'd5462;
      4'd13:   r = 17'd5042;
      4'd14:   r = 17'd4682;
      default: r = 17'd4370;
    endcase
    return r;
  endfunction

endpackage

>>> src/spb_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload beat of type T.
// Used for the configuration, input and result channels; no dependencies.
interface spb_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/spb_ram.sv
`timescale 1ns / 1ps
// Generic simple dual port RAM: one write port, one read port, registered read data.
// No dependencies.
module spb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/sprite_pixel_blitter.sv
`timescale 1ns / 1ps
// Sprite pixel blitter top level: scale, clip, mirror, sheet lookup and color key.
// Depends on spb_pkg, spb_stream_if, spb_ram and assert_macros.svh.
//
// Usage:
//   cfg_i  : register writes (index, wdata); always ready. Write only while idle.
//   in_i   : one beat per item. cmd 0 stores load_pixel at load_addr in the sheet
//            RAM; cmd 1 queries target pixel (target_x, target_y).
//   out_o  : exactly one result beat per input beat, in order. A load gives an
//            all-zero result; a query gives write_enable with color and address,
//            or all zeros when the pixel is clipped or color-keyed.
// Path: stage 1 input register, stage 2 registers, sheet RAM read data with stage 3
//   registers, result queue. Throughput: one item per clock while in_i.ready is high,
//   set by the single sheet RAM access (one write or one read) each item makes in stage 2.
// Reset: pipeline and result queue empty, registers at their defaults. The
//   sheet RAM is not cleared; a query may only hit entries loaded before.
// Stall: the pipeline never stops; results land in an 8-entry queue. in_i.ready
//   drops when queued plus in-flight items fill the queue, so nothing is lost.
`include "assert_macros.svh"

module sprite_pixel_blitter #(
  parameter int unsigned SHEET_PIXELS  = 4096,
  parameter int unsigned TARGET_WIDTH  = 1024,
  parameter int unsigned TARGET_HEIGHT = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  spb_stream_if.sink   cfg_i,
  spb_stream_if.sink   in_i,
  spb_stream_if.source out_o
);
  import spb_pkg::*;

  localparam int unsigned AW    = $clog2(SHEET_PIXELS);
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [11:0] origin_x_q, origin_y_q;
  logic [3:0]         scale_q;
  logic               flip_q;
  logic [5:0]         frame_index_q;
  logic [6:0]         frame_w_q, frame_h_q, frames_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      scale_q       <= 4'd1;
      flip_q        <= 1'b0;
      frame_index_q <= '0;
      frame_w_q     <= 7'd16;
      frame_h_q     <= 7'd16;
      frames_q      <= 7'd1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        CFG_ORIGIN_X:    origin_x_q    <= cfg_i.data.wdata;
        CFG_ORIGIN_Y:    origin_y_q    <= cfg_i.data.wdata;
        CFG_SCALE:       scale_q       <= cfg_i.data.wdata[3:0];
        CFG_FLIP:        flip_q        <= cfg_i.data.wdata[0];
        CFG_FRAME_INDEX: frame_index_q <= cfg_i.data.wdata[5:0];
        CFG_FRAME_W:     frame_w_q     <= cfg_i.data.wdata[6:0];
        CFG_FRAME_H:     frame_h_q     <= cfg_i.data.wdata[6:0];
        CFG_FRAMES:      frames_q      <= cfg_i.data.wdata[6:0];
        default: ;
      endcase
    end
  end

  // Values derived from the registers; they settle in the cycle after a write,
  // before any item accepted after that write reaches them.
  logic [3:0]         scale_eff;
  logic [RECIP_W-1:0] recip_q;
  logic [10:0]        ext_x_q, ext_y_q;
  logic [13:0]        stride_q;
  logic [12:0]        base_q;

  assign scale_eff = (scale_q == 4'd0) ? 4'd1 : scale_q;

  always_ff @(posedge clk_i) begin
    recip_q  <= scale_recip(scale_q);
    ext_x_q  <= 11'(11'(frame_w_q) * 11'(scale_eff));
    ext_y_q  <= 11'(11'(frame_h_q) * 11'(scale_eff));
    stride_q <= 14'(14'(frames_q) * 14'(frame_w_q));
    base_q   <= 13'(13'(frame_index_q) * 13'(frame_w_q));
  end

  // ---------------------------------------------------------------------------
  // Result queue bookkeeping and input flow control
  // ---------------------------------------------------------------------------
  logic             p1_v_q, p2_v_q, p3_v_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] inflight;
  logic             in_fire, push, pop;

  assign inflight = CNT_W'(p1_v_q) + CNT_W'(p2_v_q) + CNT_W'(p3_v_q);
  // Hold off new beats while the queue has no room for one more item beyond those in flight
  assign in_i.ready = (cnt_q + inflight) < CNT_W'(FIFO_DEPTH);
  assign in_fire    = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------------
  // Stage 1: origin offset, clipping, reciprocal multiply
  // ---------------------------------------------------------------------------
  in_t                p1_q;
  logic signed [13:0] dx, dy;
  logic               x_in, y_in, tgt_ok, hit1;
  logic [27:0]        prodx_d, prody_d;
  logic [19:0]        taddr_d;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      p1_q <= in_i.data;
    end
  end

  always_comb begin
    dx      = $signed({4'b0000, p1_q.target_x}) - 14'(origin_x_q);
    dy      = $signed({4'b0000, p1_q.target_y}) - 14'(origin_y_q);
    x_in    = !dx[13] && (dx[12:0] < {2'b00, ext_x_q});
    y_in    = !dy[13] && (dy[12:0] < {2'b00, ext_y_q});
    tgt_ok  = ({22'b0, p1_q.target_x} < 32'(TARGET_WIDTH))
           && ({22'b0, p1_q.target_y} < 32'(TARGET_HEIGHT));
    hit1    = p1_q.cmd && tgt_ok && x_in && y_in;
    // Floor division by the scale: offsets in range stay below 2048
    prodx_d = 28'(dx[10:0]) * 28'(recip_q);
    prody_d = 28'(dy[10:0]) * 28'(recip_q);
    taddr_d = 20'(32'(p1_q.target_y) * 32'(TARGET_WIDTH) + 32'(p1_q.target_x));
  end

  // ---------------------------------------------------------------------------
  // Stage 2: sheet index, RAM read for queries or write for loads
  // ---------------------------------------------------------------------------
  logic        p2_cmd_q, p2_hit_q;
  logic [27:0] p2_prodx_q, p2_prody_q;
  logic [19:0] p2_taddr_q;
  logic [11:0] p2_laddr_q;
  logic [31:0] p2_lpix_q;
  logic [6:0]  col, row, col_m;
  logic [21:0] idx;
  logic        idx_ok, load_ok;
  logic        ram_we, ram_re;
  logic [31:0] ram_rdata;

  always_ff @(posedge clk_i) begin
    p2_cmd_q   <= p1_q.cmd;
    p2_hit_q   <= hit1;
    p2_prodx_q <= prodx_d;
    p2_prody_q <= prody_d;
    p2_taddr_q <= taddr_d;
    p2_laddr_q <= p1_q.load_addr;
    p2_lpix_q  <= p1_q.load_pixel;
  end

  always_comb begin
    col     = 7'(p2_prodx_q >> RECIP_SHIFT);
    row     = 7'(p2_prody_q >> RECIP_SHIFT);
    // Mirror the column inside the frame
    col_m   = flip_q ? (frame_w_q - 7'd1 - col) : col;
    idx     = 22'(row) * 22'(stride_q) + 22'(base_q) + 22'(col_m);
    idx_ok  = 32'(idx) < SHEET_PIXELS;
    load_ok = 32'(p2_laddr_q) < SHEET_PIXELS;
    ram_re  = p2_v_q && p2_hit_q && idx_ok;
    ram_we  = p2_v_q && !p2_cmd_q && load_ok;
  end

  // A load writes and a later query reads in a later cycle, so the read sees it
  spb_ram #(
    .WIDTH (32),
    .DEPTH (SHEET_PIXELS)
  ) u_sheet (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(p2_laddr_q)),
    .wdata_i (p2_lpix_q),
    .re_i    (ram_re),
    .raddr_i (AW'(idx)),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 3: color key and result
  // ---------------------------------------------------------------------------
  logic        p3_hit_q;
  logic [19:0] p3_taddr_q;
  out_t        res_d;

  always_ff @(posedge clk_i) begin
    p3_hit_q   <= ram_re;
    p3_taddr_q <= p2_taddr_q;
  end

  always_comb begin
    res_d.write_enable = p3_hit_q && ((ram_rdata & ALPHA_MASK) != '0)
                      && ((ram_rdata & COLOR_MASK) != '0);
    res_d.pixel_color  = res_d.write_enable ? ram_rdata : '0;
    res_d.target_addr  = res_d.write_enable ? p3_taddr_q : '0;
  end

  // Advance the valid bits every cycle; the queue always has room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
    end else begin
      p1_v_q <= in_fire;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------------
  out_t             fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;

  assign push  = p3_v_q;
  assign pop   = out_o.valid && out_o.ready;
  assign cnt_d = cnt_q + CNT_W'(push) - CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  assign out_o.valid = (cnt_q != '0);
  assign out_o.data  = fifo_q[rd_ptr_q];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_ram_one_access, clk_i, rst_ni, !(ram_we && ram_re), "sheet RAM read and write in one cycle")
  `ASSERT_ALWAYS(a_queue_credit, clk_i, rst_ni, (cnt_q + inflight) <= CNT_W'(FIFO_DEPTH), "result queue overcommitted")
  `ASSERT_IMPLIES(a_push_room, clk_i, rst_ni, push && !pop, cnt_q < CNT_W'(FIFO_DEPTH), "result queue overflow")
  `ASSERT_IMPLIES(a_no_write_zero, clk_i, rst_ni, out_o.valid && !out_o.data.write_enable, (out_o.data.pixel_color == '0) && (out_o.data.target_addr == '0), "nonzero payload without write")

endmodule

>>> sim/tb_sprite_pixel_blitter.sv
`timescale 1ns / 1ps
// Self-checking testbench of sprite_pixel_blitter: sheet loads, pixel queries, color key.
// Depends on spb_pkg, spb_stream_if and the block itself; needs no files at run time.
module tb_sprite_pixel_blitter;
  import spb_pkg::*;

  localparam int unsigned SHEET_PIXELS  = 4096;
  localparam int unsigned TARGET_WIDTH  = 1024;
  localparam int unsigned TARGET_HEIGHT = 1024;

  // Item kinds carried in the cmd field
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Index outside the register map; a write there must change nothing
  localparam cfg_idx_t CFG_SPARE = 4'd15;

  localparam int unsigned IDLE_PCT      = 35;
  localparam int unsigned SETTLE_CYCLES = 8;       // a margin past the input-to-result delay of the pipeline
  localparam int unsigned MAX_CYCLES    = 300000;

  logic clk_i;
  logic rst_ni;

  spb_stream_if #(.T(cfg_t)) cfg_if ();
  spb_stream_if #(.T(in_t))  in_if ();
  spb_stream_if #(.T(out_t)) out_if ();

  sprite_pixel_blitter #(
    .SHEET_PIXELS (SHEET_PIXELS),
    .TARGET_WIDTH (TARGET_WIDTH),
    .TARGET_HEIGHT(TARGET_HEIGHT)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Register shadow, updated on each accepted register write beat
  logic [11:0] cur_origin_x  = 12'd0;
  logic [11:0] cur_origin_y  = 12'd0;
  logic [3:0]  cur_scale     = 4'd1;
  logic        cur_flip      = 1'b0;
  logic [5:0]  cur_frame_idx = 6'd0;
  logic [6:0]  cur_fw        = 7'd16;
  logic [6:0]  cur_fh        = 7'd16;
  logic [6:0]  cur_frames    = 7'd1;

  // Sheet contents as the block should hold them, and which entries the
  // stimulus has already filled (a query must never reach an unfilled one)
  logic [31:0] sheet_mirror [SHEET_PIXELS];
  bit          sheet_loaded [SHEET_PIXELS];

  in_t  beat_queue[$];     // items waiting for the driver
  out_t blit_results[$];   // results still owed by the block, oldest first

  bit          steady;     // set during the stretch with no idling on either side
  bit          in_taken;
  out_t        want_px;
  int unsigned mismatches;
  int unsigned loads_seen, queries_seen, writes_seen, reg_writes, settings;
  int unsigned cycles;

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------

  // Map a target pixel onto the sheet. Return 1 when the pixel lies inside the
  // drawn frame and the sheet entry it lands on exists; entry names that entry.
  function automatic bit sheet_hit(input logic [9:0] tx, input logic [9:0] ty,
                                   output int unsigned entry);
    int s, ox, oy, fw, fh, dx, dy, col, row, idx;
    entry = 0;
    s  = (cur_scale == 4'd0) ? 1 : int'(cur_scale);
    ox = $signed(cur_origin_x);
    oy = $signed(cur_origin_y);
    fw = int'(cur_fw);
    fh = int'(cur_fh);
    if (tx >= TARGET_WIDTH || ty >= TARGET_HEIGHT) return 1'b0;
    dx = int'(tx) - ox;
    dy = int'(ty) - oy;
    // Offsets are nonnegative past this point, so the division is a plain floor
    if (dx < 0 || dy < 0 || dx >= fw * s || dy >= fh * s) return 1'b0;
    col = dx / s;
    row = dy / s;
    if (cur_flip) col = fw - 1 - col;
    idx = row * (int'(cur_frames) * fw) + int'(cur_frame_idx) * fw + col;
    if (idx >= int'(SHEET_PIXELS)) return 1'b0;
    entry = idx;
    return 1'b1;
  endfunction

  // Apply one accepted item to the sheet copy and queue the result it owes
  function automatic void blit_pixel(input in_t b);
    out_t        r;
    int unsigned entry;
    logic [31:0] c;
    r = '0;
    if (b.cmd == CMD_LOAD) begin
      if (b.load_addr < SHEET_PIXELS) sheet_mirror[b.load_addr] = b.load_pixel;
      loads_seen++;
    end else begin
      queries_seen++;
      if (sheet_hit(b.target_x, b.target_y, entry)) begin
        c = sheet_mirror[entry];
        // Color key: a write needs both some alpha and some color
        if ((c & ALPHA_MASK) != '0 && (c & COLOR_MASK) != '0) begin
          r.write_enable = 1'b1;
          r.pixel_color  = c;
          r.target_addr  = 20'(int'(b.target_y) * TARGET_WIDTH + int'(b.target_x));
        end
      end
    end
    blit_results.push_back(r);
  endfunction

  function automatic void apply_reg(input cfg_idx_t idx, input logic [11:0] val);
    case (idx)
      CFG_ORIGIN_X:    cur_origin_x  = val;
      CFG_ORIGIN_Y:    cur_origin_y  = val;
      CFG_SCALE:       cur_scale     = val[3:0];
      CFG_FLIP:        cur_flip      = val[0];
      CFG_FRAME_INDEX: cur_frame_idx = val[5:0];
      CFG_FRAME_W:     cur_fw        = val[6:0];
      CFG_FRAME_H:     cur_fh        = val[6:0];
      CFG_FRAMES:      cur_frames    = val[6:0];
      default: ;
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  // Pick a pixel: half of the time one that passes the color key, otherwise one
  // of the keyed-out shapes, hitting every keyed-out shape
  function automatic logic [31:0] any_pixel();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return ALPHA_MASK;
      2: return COLOR_MASK;
      3: return 32'hffff_ffff;
      4: return 32'h0100_0001;
      5: return {8'($urandom_range(255, 1)), 24'h0};
      6: return {8'h0, 24'($urandom_range(24'hff_ffff, 1))};
      default: return {8'($urandom_range(255, 1)), 24'($urandom_range(24'hff_ffff, 1))};
    endcase
  endfunction

  // Fill every field at random; the caller overwrites the ones that matter
  function automatic in_t filler_beat();
    in_t b;
    b.cmd        = 1'($urandom);
    b.load_addr  = 12'($urandom);
    b.load_pixel = $urandom;
    b.target_x   = 10'($urandom);
    b.target_y   = 10'($urandom);
    return b;
  endfunction

  function automatic void queue_load(input int unsigned addr, input logic [31:0] pix);
    in_t b;
    b = filler_beat();
    b.cmd        = CMD_LOAD;
    b.load_addr  = 12'(addr);
    b.load_pixel = pix;
    if (addr < SHEET_PIXELS) sheet_loaded[addr] = 1'b1;
    beat_queue.push_back(b);
  endfunction

  // Queue a query; load its sheet entry first when nothing has been stored there.
  // Uses the current register shadow, which is stable while items are queued.
  function automatic void queue_query(input int tx, input int ty);
    in_t         b;
    int unsigned entry;
    if (sheet_hit(10'(tx), 10'(ty), entry) && !sheet_loaded[entry])
      queue_load(entry, any_pixel());
    b = filler_beat();
    b.cmd      = CMD_QUERY;
    b.target_x = 10'(tx);
    b.target_y = 10'(ty);
    beat_queue.push_back(b);
  endfunction

  // Coordinate around the sprite's span on one axis, a few pixels past both edges
  function automatic int near_coord(input int org, input int span);
    int c;
    c = org - 3 + int'($urandom_range(span + 6));
    if (c < 0 || c > int'(TARGET_WIDTH) - 1) c = $urandom_range(TARGET_WIDTH - 1);
    return c;
  endfunction

  // Mix of stray loads, scattered queries and queries around the sprite;
  // count includes the loads that queries pull in ahead of themselves
  function automatic void queue_random(input int unsigned count);
    int          s, roll;
    int unsigned goal;
    s = (cur_scale == 4'd0) ? 1 : int'(cur_scale);
    goal = beat_queue.size() + count;
    while (beat_queue.size() < goal) begin
      roll = $urandom_range(99);
      if (roll < 12) queue_load($urandom_range(SHEET_PIXELS - 1), any_pixel());
      else if (roll < 20) queue_query($urandom_range(1023), $urandom_range(1023));
      else queue_query(near_coord($signed(cur_origin_x), int'(cur_fw) * s),
                       near_coord($signed(cur_origin_y), int'(cur_fh) * s));
    end
  endfunction

  // One register write beat; the register shadow follows at the accepting edge
  task automatic write_reg(input cfg_idx_t idx, input logic [11:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, wdata: val};
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    apply_reg(idx, val);
    reg_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Write a field of w bits; fill the bits above it with junk the block must drop
  task automatic write_field(input cfg_idx_t idx, input int val, input int unsigned w);
    logic [11:0] mask;
    mask = 12'((1 << w) - 1);
    write_reg(idx, (12'($urandom) & ~mask) | (12'(val) & mask));
  endtask

  task automatic set_sprite(input int ox, input int oy, input int sc, input int fl,
                            input int fi, input int fw, input int fh, input int fr);
    if ($urandom_range(3) == 0) write_reg(CFG_SPARE, 12'($urandom));
    write_field(CFG_ORIGIN_X,    ox, 12);
    write_field(CFG_ORIGIN_Y,    oy, 12);
    write_field(CFG_SCALE,       sc, 4);
    write_field(CFG_FLIP,        fl, 1);
    write_field(CFG_FRAME_INDEX, fi, 6);
    write_field(CFG_FRAME_W,     fw, 7);
    write_field(CFG_FRAME_H,     fh, 7);
    write_field(CFG_FRAMES,      fr, 7);
    settings++;
  endtask

  // Hold until every queued item went in and every owed result came out, then
  // let the pipeline settle before anyone touches the registers
  task automatic drain();
    while (beat_queue.size() != 0 || in_if.valid || blit_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // -------------------------------------------------------------------------
  // Clock, driver, monitor, watchdog
  // -------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Input side: note the beat taken at each rising edge and predict its result
  always @(posedge clk_i) begin
    in_taken <= in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) blit_pixel(in_if.data);
  end

  // Advance to the next item once the current one is taken, or hold it.
  // Idle at random except during the steady stretch.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (beat_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_if.valid <= 1'b1;
        in_if.data  <= beat_queue.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result side: stall at random; compare each taken beat with the oldest
  // owed result
  always @(negedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (blit_results.size() == 0) begin
        $error("result beat with nothing owed: %p", out_if.data);
        mismatches++;
      end else begin
        want_px = blit_results.pop_front();
        check_field("write_enable", 32'(want_px.write_enable), 32'(out_if.data.write_enable));
        check_field("pixel_color", want_px.pixel_color, out_if.data.pixel_color);
        check_field("target_addr", 32'(want_px.target_addr), 32'(out_if.data.target_addr));
        if (out_if.data.write_enable === 1'b1) writes_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, blit_results.size());
      $display("tb_sprite_pixel_blitter: done, errors");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------

  initial begin
    int ox, oy, sc, fl, fi, fw, fh, fr;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    steady       = 1'b0;
    in_taken     = 1'b0;
    cycles       = 0;
    mismatches   = 0;
    foreach (sheet_loaded[i]) sheet_loaded[i] = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset settings: a 16x16 frame at the origin, scale 1,
    // so sheet entry = row * 16 + column
    queue_load(0,    32'hffff_ffff);
    queue_load(SHEET_PIXELS - 1, 32'h0100_0001);  // top address
    queue_load(15,   ALPHA_MASK);                 // alpha only: keyed out
    queue_load(240,  COLOR_MASK);                 // color only: keyed out
    queue_load(255,  32'h0100_0001);              // smallest alpha and color
    queue_load(17,   32'h0);                      // fully transparent
    queue_query(0, 0);
    queue_query(15, 0);
    queue_query(0, 15);
    queue_query(15, 15);
    queue_query(1, 1);
    queue_query(16, 0);                           // just right of the frame
    queue_query(0, 16);                           // just below the frame
    queue_query(1023, 1023);
    queue_query(1023, 0);
    queue_query(0, 1023);
    queue_load(0, 32'h8000_0001);                 // overwrite, then read back
    queue_query(0, 0);
    drain();

    // Corner settings. Zero scale acting as one, single-pixel frame, mirrored
    set_sprite(0, 0, 0, 1, 0, 1, 1, 1);
    queue_random(40);
    drain();
    // Every field at an end of its range; the sprite sits entirely off target
    set_sprite(-2048, 2047, 15, 0, 63, 127, 127, 127);
    queue_random(40);
    drain();
    // Scale above 8, last frame of a wide sheet: only row 0 fits, reaches the
    // last sheet entry; rows past it fall off the sheet
    set_sprite(-20, -5, 9, 1, 63, 64, 64, 64);
    queue_random(40);
    drain();
    // Zero frame width draws nothing
    set_sprite(10, 10, 2, 0, 1, 0, 8, 2);
    queue_random(40);
    drain();
    // Zero frame height draws nothing
    set_sprite(30, 40, 3, 1, 0, 8, 0, 1);
    queue_random(40);
    drain();
    // Origin past the target on x, far above it on y
    set_sprite(2047, -2048, 1, 0, 0, 16, 16, 1);
    queue_random(40);
    drain();
    // Sprite hanging off the bottom right corner of the target
    set_sprite(1000, 1000, 8, 1, 2, 8, 8, 4);
    queue_random(40);
    drain();

    // Random settings; one of them runs with no idling on either side
    for (int ph = 0; ph < 9; ph++) begin
      ox = int'($urandom_range(1100)) - 60;
      oy = int'($urandom_range(1100)) - 60;
      sc = ($urandom_range(4) == 0) ? int'($urandom_range(15)) : int'($urandom_range(8, 1));
      fl = $urandom_range(1);
      fw = ($urandom_range(3) == 0) ? $urandom_range(64, 1) : $urandom_range(16, 1);
      fh = ($urandom_range(3) == 0) ? $urandom_range(64, 1) : $urandom_range(16, 1);
      fr = $urandom_range(8, 1);
      fi = ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(fr - 1);
      set_sprite(ox, oy, sc, fl, fi, fw, fh, fr);
      steady = (ph == 4);
      queue_random(steady ? 150 : 90);
      drain();
      steady = 1'b0;
    end

    // drain() only returns once nothing is owed; anything left is a failure
    if (blit_results.size() != 0) begin
      $error("%0d results never arrived", blit_results.size());
      mismatches++;
    end
    $display("covered %0d loads and %0d queries (%0d pixel writes) over %0d settings,",
             loads_seen, queries_seen, writes_seen, settings);
    $display("  %0d register writes, %0d mismatches", reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("tb_sprite_pixel_blitter: done, clean");
    end else begin
      $display("tb_sprite_pixel_blitter: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/spb_pkg.sv
src/spb_stream_if.sv
src/spb_ram.sv
src/sprite_pixel_blitter.sv
sim/tb_sprite_pixel_blitter.sv
